### rtl/core/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define SIDAU_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SIDAU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### rtl/core/sidau_pkg.sv
// Package: beat types, constants and helpers for the decimal ASCII unit.
`timescale 1ns / 1ps

package sidau_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_VALUE_W     = 32;
  localparam int COUNT_W        = 31;
  localparam int CHAR_W         = 8;
  // queue depth, power of two so pointers wrap on their own
  localparam int Q_DEPTH        = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0]  ASCII_MINUS = 8'h2D;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [COUNT_W-1:0]    count_before;
  } in_beat_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  char_byte;
    logic               last;
    logic [COUNT_W-1:0] count_after;
  } out_beat_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } bk_state_t;

  // upper bound on decimal digits of a magnitude up to 2^(vb-1)
  function automatic int max_digits(input int vb);
    return ((vb * 1233) >> 12) + 1;
  endfunction

endpackage

### rtl/core/sidau_front.sv
// Front stage: takes a beat, sign-extends and forms the magnitude, pushes to the queue.
`timescale 1ns / 1ps

module sidau_front import sidau_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int ENTRY_W    = VALUE_BITS + COUNT_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_beat_t           in_beat,
  input  q_stat_t            q_stat,
  output logic               push,
  output logic [ENTRY_W-1:0] push_data
);

  localparam int EXT_W = (VALUE_BITS > IN_VALUE_W) ? VALUE_BITS : IN_VALUE_W;

  logic                  vld_r, vld_nxt;
  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic                  neg_r, neg_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;

  logic signed [EXT_W-1:0] ext;
  logic [VALUE_BITS-1:0]   raw;
  logic                    accept;

  assign ext    = EXT_W'($signed(in_beat.value));
  assign raw    = ext[VALUE_BITS-1:0];
  assign busy   = vld_r & q_stat.full;
  assign accept = start & ~busy;
  assign push   = vld_r & ~q_stat.full;
  assign push_data = {neg_r, mag_r, cnt_r};

  always_comb begin
    vld_nxt = accept | (vld_r & ~push);
    mag_nxt = mag_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      neg_nxt = raw[VALUE_BITS-1];
      mag_nxt = raw[VALUE_BITS-1] ? (~raw + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : raw;
      cnt_nxt = in_beat.count_before;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    mag_r <= mag_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

### rtl/core/sidau_queue.sv
// Short register queue between the front and back stages.
`timescale 1ns / 1ps

module sidau_queue import sidau_pkg::*; #(
  parameter int WIDTH = VALUE_BITS_DEF + COUNT_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output q_stat_t          q_stat
);

  localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CNT_W = $clog2(Q_DEPTH + 1);

  logic [WIDTH-1:0] mem_r [Q_DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt;
  logic [PTR_W-1:0] rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign q_stat.full  = (cnt_r == CNT_W'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push  = push & ~q_stat.full;
  assign do_pop   = pop & ~q_stat.empty;
  assign pop_data = mem_r[rp_r];

  always_comb begin
    wp_nxt  = do_push ? wp_r + PTR_W'(1) : wp_r;
    rp_nxt  = do_pop  ? rp_r + PTR_W'(1) : rp_r;
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

endmodule

### rtl/core/sidau_back.sv
// Back stage: serial shift-add binary to BCD, then one character beat per cycle.
`timescale 1ns / 1ps

module sidau_back import sidau_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF,
  parameter int ENTRY_W    = VALUE_BITS + COUNT_W + 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  q_stat_t            q_stat,
  input  logic [ENTRY_W-1:0] pop_data,
  output logic               pop,
  output logic               out_strobe,
  output out_beat_t          out_beat
);

  localparam int D     = max_digits(VALUE_BITS);
  localparam int IDX_W = (D > 1) ? $clog2(D) : 1;
  localparam int NDW   = $clog2(D + 1);
  localparam int BC_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  bk_state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] sh_r, sh_nxt;
  logic [D-1:0][3:0]     bcd_r, bcd_nxt;
  logic [NDW-1:0]        ndig_r, ndig_nxt;
  logic [BC_W-1:0]       bit_r, bit_nxt;
  logic [IDX_W-1:0]      pos_r, pos_nxt;
  logic                  neg_r, neg_nxt;
  logic [COUNT_W-1:0]    cnt_r, cnt_nxt;

  logic [D-1:0][3:0]     adj;
  logic [D*4-1:0]        adj_flat;
  logic [D-1:0][3:0]     bcd_step;
  logic                  grow;
  logic [COUNT_W-1:0]    cnt_inc;
  logic                  conv_done;
  logic                  emit_last;

  always_comb begin
    for (int i = 0; i < D; i++) begin
      adj[i] = (bcd_r[i] >= 4'd5) ? bcd_r[i] + 4'd3 : bcd_r[i];
    end
  end

  assign adj_flat  = adj;
  assign bcd_step  = {adj_flat[D*4-2:0], sh_r[VALUE_BITS-1]};
  assign grow      = (ndig_r < NDW'(D)) && (bcd_step[ndig_r[IDX_W-1:0]] != 4'd0);
  assign cnt_inc   = (cnt_r == COUNT_MAX) ? cnt_r : cnt_r + COUNT_W'(1);
  assign conv_done = (bit_r == '0);
  assign emit_last = ~neg_r && (pos_r == '0);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BK_IDLE: if (!q_stat.empty) state_nxt = BK_CONV;
      BK_CONV: if (conv_done) state_nxt = BK_EMIT;
      BK_EMIT: if (emit_last) state_nxt = BK_IDLE;
      default: state_nxt = BK_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop                  = 1'b0;
    out_strobe           = 1'b0;
    out_beat.char_byte   = neg_r ? ASCII_MINUS : ASCII_ZERO + {4'b0000, bcd_r[pos_r]};
    out_beat.last        = emit_last;
    out_beat.count_after = cnt_inc;
    unique case (state_r)
      BK_IDLE: pop = ~q_stat.empty;
      BK_CONV: pop = 1'b0;
      BK_EMIT: out_strobe = 1'b1;
      default: pop = 1'b0;
    endcase
  end

  // datapath
  always_comb begin
    sh_nxt   = sh_r;
    bcd_nxt  = bcd_r;
    ndig_nxt = ndig_r;
    bit_nxt  = bit_r;
    pos_nxt  = pos_r;
    neg_nxt  = neg_r;
    cnt_nxt  = cnt_r;
    unique case (state_r)
      BK_IDLE: begin
        if (!q_stat.empty) begin
          neg_nxt  = pop_data[ENTRY_W-1];
          sh_nxt   = pop_data[COUNT_W +: VALUE_BITS];
          cnt_nxt  = pop_data[COUNT_W-1:0];
          bcd_nxt  = '0;
          ndig_nxt = NDW'(1);
          bit_nxt  = BC_W'(VALUE_BITS - 1);
        end
      end
      BK_CONV: begin
        sh_nxt  = sh_r << 1;
        bcd_nxt = bcd_step;
        bit_nxt = bit_r - BC_W'(1);
        if (grow) begin
          ndig_nxt = ndig_r + NDW'(1);
        end
        if (conv_done) begin
          pos_nxt = IDX_W'(ndig_nxt - NDW'(1));
        end
      end
      BK_EMIT: begin
        cnt_nxt = cnt_inc;
        if (neg_r) begin
          neg_nxt = 1'b0;
        end else begin
          pos_nxt = pos_r - IDX_W'(1);
        end
      end
      default: begin
        sh_nxt = sh_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    sh_r   <= sh_nxt;
    bcd_r  <= bcd_nxt;
    ndig_r <= ndig_nxt;
    bit_r  <= bit_nxt;
    pos_r  <= pos_nxt;
    neg_r  <= neg_nxt;
    cnt_r  <= cnt_nxt;
  end

endmodule

### rtl/core/signed_int_to_decimal_ascii_unit.sv
// Top level: signed integer to decimal ASCII, one character beat per cycle while emitting.
// A number taken at start passes the front register and the queue, then the back stage
// pops it, converts it with the one-bit-per-cycle shift-add BCD converter and emits its
// characters, minus sign first.
// A two-entry queue lets the front take up to three numbers ahead; busy shows it is full.
// Results are strobed and cannot be stalled. Synchronous reset empties front, queue and back.
`timescale 1ns / 1ps

module signed_int_to_decimal_ascii_unit import sidau_pkg::*; #(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_beat_t  in_beat,
  output logic      out_strobe,
  output out_beat_t out_beat
);

  localparam int ENTRY_W = VALUE_BITS + COUNT_W + 1;

  q_stat_t            q_stat;
  logic               push;
  logic               pop;
  logic [ENTRY_W-1:0] push_data;
  logic [ENTRY_W-1:0] pop_data;

  sidau_front #(
    .VALUE_BITS (VALUE_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_beat   (in_beat),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  sidau_queue #(
    .WIDTH (ENTRY_W)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  sidau_back #(
    .VALUE_BITS (VALUE_BITS),
    .ENTRY_W    (ENTRY_W)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_strobe (out_strobe),
    .out_beat   (out_beat)
  );

endmodule

### rtl/core/sidau_checker.sv
// Port-level checker for the decimal ASCII unit, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sidau_checker import sidau_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      out_strobe,
  input out_beat_t out_beat
);

  `SIDAU_ASSERT(a_chars_contiguous, clk, rst_n, out_strobe && !out_beat.last |=> out_strobe, "gap inside a number")
  `SIDAU_ASSERT(a_count_steps, clk, rst_n, out_strobe && !out_beat.last && out_beat.count_after != COUNT_MAX |=> out_beat.count_after == $past(out_beat.count_after) + COUNT_W'(1), "count did not advance by one")
  `SIDAU_ASSERT(a_minus_not_last, clk, rst_n, out_strobe && out_beat.char_byte == ASCII_MINUS |-> !out_beat.last, "minus sign ended a number")
  `SIDAU_ASSERT(a_char_legal, clk, rst_n, out_strobe |-> (out_beat.char_byte == ASCII_MINUS) || (out_beat.char_byte >= ASCII_ZERO && out_beat.char_byte <= ASCII_NINE), "illegal character")
  `SIDAU_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |=> !out_strobe, "strobe right after reset")

endmodule

bind signed_int_to_decimal_ascii_unit sidau_checker u_sidau_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_strobe (out_strobe),
  .out_beat   (out_beat)
);
